// File: src/mit_command_frame_packer_unit_assert.svh
// ----------------------------------------------------------------------------
// mit command frame packer assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef MIT_COMMAND_FRAME_PACKER_UNIT_ASSERT_SVH
`define MIT_COMMAND_FRAME_PACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define MCFP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mcfp_pkg.sv
// ----------------------------------------------------------------------------
// mcfp_pkg
// types and constants shared by the command frame packer and its divider
// ----------------------------------------------------------------------------
`default_nettype none

package mcfp_pkg;

    // operation codes
    localparam logic [1:0] OP_MIT     = 2'd0;
    localparam logic [1:0] OP_ENABLE  = 2'd1;
    localparam logic [1:0] OP_DISABLE = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_IDENTIFIER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIT_OFFSET       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SET_OFFSET       = 3'd5;

    // field widths
    localparam int LIMIT_W   = 31;
    localparam int IDENT_W   = 11;
    localparam int VALUE_W   = 32;
    localparam int PAYLOAD_W = 64;
    localparam int LENGTH_W  = 4;

    // divider geometry: quotient bits, divisor and numerator widths
    localparam int QUO_W = 16;
    localparam int DEN_W = 32;
    localparam int NUM_W = DEN_W + QUO_W;

    // code widths
    localparam int POS_BITS  = 16;
    localparam int CODE_BITS = 12;

    // gain ranges, Q15.16 (500.0 and 5.0)
    localparam int GAIN_W = 25;
    localparam logic [GAIN_W-1:0] KP_TOP = 25'd32768000;
    localparam logic [GAIN_W-1:0] KD_TOP = 25'd327680;

    // gain codes by reciprocal multiply: shift out the power-of-two part of
    // the range (500.0 = 125 * 2^18, 5.0 = 5 * 2^16), then multiply by the
    // rounded-up reciprocal of the odd part and shift
    localparam int KP_PRE_SHIFT  = 18;
    localparam int KP_SCALED_W   = 19;
    localparam int KP_RECIP_W    = 20;
    localparam int KP_PROD_W     = KP_SCALED_W + KP_RECIP_W;
    localparam int KP_POST_SHIFT = 26;
    localparam logic [KP_RECIP_W-1:0] KP_RECIP = 20'd536871;
    localparam int KD_PRE_SHIFT  = 16;
    localparam int KD_SCALED_W   = 15;
    localparam int KD_RECIP_W    = 16;
    localparam int KD_PROD_W     = KD_SCALED_W + KD_RECIP_W;
    localparam int KD_POST_SHIFT = 18;
    localparam logic [KD_RECIP_W-1:0] KD_RECIP = 16'd52429;

    // fixed frames
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_ENABLE  = 64'hFFFF_FFFF_FFFF_FFFC;
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_DISABLE = 64'hFFFF_FFFF_FFFF_FFFD;
    localparam logic [LENGTH_W-1:0]  FRAME_LENGTH    = 4'd8;

    // per-item control carried down the pipeline
    typedef struct packed {
        logic               is_mit;
        logic               is_disable;
        logic [IDENT_W-1:0] ident;
    } frame_meta_t;

    // gain codes carried alongside the dividers
    typedef struct packed {
        logic [CODE_BITS-1:0] kp;
        logic [CODE_BITS-1:0] kd;
    } gain_codes_t;

endpackage

`default_nettype wire

// File: src/mit_command_frame_packer_unit.sv
// ----------------------------------------------------------------------------
// mit_command_frame_packer_unit
// builds one motor command frame per transaction: clamps and quantizes the
// mit command fields, or emits the fixed enable and disable frames
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      in_valid / in_ready       operation, five q15.16 values
//  out      output     out_valid / out_ready     identifier, payload, length
//  cfg      input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  one transaction per cycle while no result is held; a result passes through
//  clamp, numerator, 16 divider stages and output register (19 registers)
//  16-stage restoring dividers on position, velocity and torque set the depth
//  a held result freezes the whole pipeline, bubbles too, and drops in_ready
//  reset clears valid bits and loads the register defaults; cfg_ready is high
//  operation 3 is accepted and produces no frame
// ----------------------------------------------------------------------------
`default_nettype none

`include "mit_command_frame_packer_unit_assert.svh"

module mit_command_frame_packer_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           operation,
    input  wire logic signed [mcfp_pkg::VALUE_W-1:0]  target_position,
    input  wire logic signed [mcfp_pkg::VALUE_W-1:0]  target_velocity,
    input  wire logic signed [mcfp_pkg::VALUE_W-1:0]  stiffness_gain,
    input  wire logic signed [mcfp_pkg::VALUE_W-1:0]  damping_gain,
    input  wire logic signed [mcfp_pkg::VALUE_W-1:0]  feedforward_torque,

    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [mcfp_pkg::IDENT_W-1:0]              frame_identifier,
    output logic [mcfp_pkg::PAYLOAD_W-1:0]            frame_payload,
    output logic [mcfp_pkg::LENGTH_W-1:0]             frame_length,

    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [mcfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mcfp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mcfp_pkg::*;

    localparam int NUM_LANES = 3;
    localparam int LANE_POS  = 0;
    localparam int LANE_VEL  = 1;
    localparam int LANE_TRQ  = 2;

    // configuration registers
    logic [LIMIT_W-1:0] position_limit_reg;
    logic [LIMIT_W-1:0] velocity_limit_reg;
    logic [LIMIT_W-1:0] torque_limit_reg;
    logic [IDENT_W-1:0] motor_identifier_reg;
    logic [IDENT_W-1:0] mit_offset_reg;
    logic [IDENT_W-1:0] set_offset_reg;

    // pipeline control
    logic advance;

    // clamp stage
    logic                     s1_valid_reg;
    frame_meta_t              s1_meta_reg;
    logic signed [VALUE_W-1:0] s1_pos_reg;
    logic signed [VALUE_W-1:0] s1_vel_reg;
    logic signed [VALUE_W-1:0] s1_trq_reg;
    logic [GAIN_W-1:0]        s1_kp_reg;
    logic [GAIN_W-1:0]        s1_kd_reg;
    logic                     s1_valid_next;
    frame_meta_t              s1_meta_next;
    logic [IDENT_W:0]         ident_sum;

    // numerator stage
    logic                   s2_valid_reg;
    frame_meta_t            s2_meta_reg;
    logic [NUM_W-1:0]       s2_num_reg [NUM_LANES];
    logic [DEN_W-1:0]       s2_den_reg [NUM_LANES];
    logic [NUM_W-1:0]       kp_num;
    logic [NUM_W-1:0]       kd_num;
    logic [KP_SCALED_W-1:0] s2_kp_scaled_reg;
    logic [KD_SCALED_W-1:0] s2_kd_scaled_reg;

    // divider stages
    logic [QUO_W-1:0] div_valid_reg;
    frame_meta_t      div_meta_reg [QUO_W];
    logic [QUO_W-1:0] lane_quo [NUM_LANES];

    // gain code stages
    logic [KP_PROD_W-1:0] kp_prod;
    logic [KD_PROD_W-1:0] kd_prod;
    gain_codes_t          gain_code_next;
    gain_codes_t          gain_code_reg [QUO_W];

    // output register
    logic                 out_valid_reg;
    logic [IDENT_W-1:0]   frame_identifier_reg;
    logic [PAYLOAD_W-1:0] frame_payload_reg;
    logic [PAYLOAD_W-1:0] payload_next;

    // clamp a signed value to plus or minus the limit
    function automatic logic signed [VALUE_W-1:0] clamp_sym(
        input logic signed [VALUE_W-1:0] x,
        input logic [LIMIT_W-1:0]        lim
    );
        logic signed [VALUE_W:0] xs;
        logic signed [VALUE_W:0] hi;
        logic signed [VALUE_W:0] lo;
        logic signed [VALUE_W:0] r;
        begin
            xs = {x[VALUE_W-1], x};
            hi = {2'b00, lim};
            lo = -hi;
            if (xs < lo)
                r = lo;
            else if (xs > hi)
                r = hi;
            else
                r = xs;
            return r[VALUE_W-1:0];
        end
    endfunction

    // clamp a gain to 0..top
    function automatic logic [GAIN_W-1:0] clamp_gain(
        input logic signed [VALUE_W-1:0] x,
        input logic [GAIN_W-1:0]         top
    );
        begin
            if (x[VALUE_W-1])
                return '0;
            else if (x[VALUE_W-2:0] > (VALUE_W-1)'(top))
                return top;
            else
                return x[GAIN_W-1:0];
        end
    endfunction

    // (x + lim) * (2^bits - 1), zero for an empty range
    function automatic logic [NUM_W-1:0] num_sym(
        input logic signed [VALUE_W-1:0] x,
        input logic [LIMIT_W-1:0]        lim,
        input int                        bits
    );
        logic [VALUE_W:0]   y_wide;
        logic [VALUE_W-1:0] y;
        begin
            y_wide = {x[VALUE_W-1], x} + {2'b00, lim};
            y      = y_wide[VALUE_W-1:0];
            if (lim == '0)
                return '0;
            else
                return (NUM_W'(y) << bits) - NUM_W'(y);
        end
    endfunction

    // 2 * lim, one for an empty range so the quotient stays zero
    function automatic logic [DEN_W-1:0] den_sym(input logic [LIMIT_W-1:0] lim);
        begin
            if (lim == '0)
                return DEN_W'(1);
            else
                return {lim, 1'b0};
        end
    endfunction

    // gain * 4095
    function automatic logic [NUM_W-1:0] num_gain(input logic [GAIN_W-1:0] g);
        begin
            return (NUM_W'(g) << CODE_BITS) - NUM_W'(g);
        end
    endfunction

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_limit_reg   <= 31'd819200;
            velocity_limit_reg   <= 31'd1966080;
            torque_limit_reg     <= 31'd655360;
            motor_identifier_reg <= 11'd1;
            mit_offset_reg       <= '0;
            set_offset_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_POSITION_LIMIT:   position_limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_VELOCITY_LIMIT:   velocity_limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_TORQUE_LIMIT:     torque_limit_reg     <= cfg_data[LIMIT_W-1:0];
                REG_MOTOR_IDENTIFIER: motor_identifier_reg <= cfg_data[IDENT_W-1:0];
                REG_MIT_OFFSET:       mit_offset_reg       <= cfg_data[IDENT_W-1:0];
                REG_SET_OFFSET:       set_offset_reg       <= cfg_data[IDENT_W-1:0];
                default:              ;
            endcase
        end
    end

    // global pipeline advance
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // clamp stage control
    always_comb
    begin
        s1_valid_next = in_valid && (operation == OP_MIT || operation == OP_ENABLE ||
                                     operation == OP_DISABLE);
        s1_meta_next.is_mit     = (operation == OP_MIT);
        s1_meta_next.is_disable = (operation == OP_DISABLE);
        ident_sum = (operation == OP_MIT)
                  ? {1'b0, motor_identifier_reg} + {1'b0, mit_offset_reg}
                  : {1'b0, motor_identifier_reg} + {1'b0, set_offset_reg};
        s1_meta_next.ident = ident_sum[IDENT_W-1:0];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            div_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            div_valid_reg <= {div_valid_reg[QUO_W-2:0], s2_valid_reg};
            out_valid_reg <= div_valid_reg[QUO_W-1];
        end
    end

    // scaled gain products
    assign kp_num = num_gain(s1_kp_reg);
    assign kd_num = num_gain(s1_kd_reg);

    // clamp stage and numerator stage data
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_meta_reg <= s1_meta_next;
            s1_pos_reg  <= clamp_sym(target_position, position_limit_reg);
            s1_vel_reg  <= clamp_sym(target_velocity, velocity_limit_reg);
            s1_trq_reg  <= clamp_sym(feedforward_torque, torque_limit_reg);
            s1_kp_reg   <= clamp_gain(stiffness_gain, KP_TOP);
            s1_kd_reg   <= clamp_gain(damping_gain, KD_TOP);

            s2_meta_reg          <= s1_meta_reg;
            s2_num_reg[LANE_POS] <= num_sym(s1_pos_reg, position_limit_reg, POS_BITS);
            s2_num_reg[LANE_VEL] <= num_sym(s1_vel_reg, velocity_limit_reg, CODE_BITS);
            s2_num_reg[LANE_TRQ] <= num_sym(s1_trq_reg, torque_limit_reg, CODE_BITS);
            s2_den_reg[LANE_POS] <= den_sym(position_limit_reg);
            s2_den_reg[LANE_VEL] <= den_sym(velocity_limit_reg);
            s2_den_reg[LANE_TRQ] <= den_sym(torque_limit_reg);
            s2_kp_scaled_reg     <= kp_num[KP_PRE_SHIFT +: KP_SCALED_W];
            s2_kd_scaled_reg     <= kd_num[KD_PRE_SHIFT +: KD_SCALED_W];
        end
    end

    // one divider per limited field
    genvar lane;
    generate
        for (lane = 0; lane < NUM_LANES; lane++) begin : g_lane
            mcfp_div_pipe u_div (
                .clk       (clk),
                .advance   (advance),
                .numerator (s2_num_reg[lane]),
                .divisor   (s2_den_reg[lane]),
                .quotient  (lane_quo[lane])
            );
        end
    endgenerate

    // gain codes by reciprocal multiply
    always_comb
    begin
        kp_prod = KP_PROD_W'(s2_kp_scaled_reg) * KP_PROD_W'(KP_RECIP);
        kd_prod = KD_PROD_W'(s2_kd_scaled_reg) * KD_PROD_W'(KD_RECIP);
        gain_code_next.kp = kp_prod[KP_POST_SHIFT +: CODE_BITS];
        gain_code_next.kd = kd_prod[KD_POST_SHIFT +: CODE_BITS];
    end

    // control and gain code shift lines alongside the dividers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_meta_reg[0]  <= s2_meta_reg;
            gain_code_reg[0] <= gain_code_next;
            for (int i = 1; i < QUO_W; i++)
            begin
                div_meta_reg[i]  <= div_meta_reg[i-1];
                gain_code_reg[i] <= gain_code_reg[i-1];
            end
        end
    end

    // frame packing
    always_comb
    begin
        if (div_meta_reg[QUO_W-1].is_mit)
            payload_next = {lane_quo[LANE_POS],
                            lane_quo[LANE_VEL][CODE_BITS-1:0],
                            gain_code_reg[QUO_W-1].kp,
                            gain_code_reg[QUO_W-1].kd,
                            lane_quo[LANE_TRQ][CODE_BITS-1:0]};
        else if (div_meta_reg[QUO_W-1].is_disable)
            payload_next = PAYLOAD_DISABLE;
        else
            payload_next = PAYLOAD_ENABLE;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            frame_identifier_reg <= div_meta_reg[QUO_W-1].ident;
            frame_payload_reg    <= payload_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign frame_identifier = frame_identifier_reg;
    assign frame_payload    = frame_payload_reg;
    assign frame_length     = FRAME_LENGTH;

    // checks
    `MCFP_ASSERT_NEXT(a_mit_enters,
        in_valid && in_ready && operation == OP_MIT,
        s1_valid_reg && s1_meta_reg.is_mit,
        "mit transaction lost at clamp stage")
    `MCFP_ASSERT_NEXT(a_stall_freezes,
        !in_ready,
        $stable(div_valid_reg),
        "divider valid line moved during stall")
    `MCFP_ASSERT_IMPLIES(a_narrow_codes,
        div_valid_reg[QUO_W-1] && div_meta_reg[QUO_W-1].is_mit,
        lane_quo[LANE_VEL][QUO_W-1:CODE_BITS] == '0 &&
            lane_quo[LANE_TRQ][QUO_W-1:CODE_BITS] == '0,
        "12-bit code overflowed")

endmodule

`default_nettype wire

// File: src/mcfp_div_pipe.sv
// ----------------------------------------------------------------------------
// mcfp_div_pipe
// pipelined restoring divider, one quotient bit per stage, msb first
// ----------------------------------------------------------------------------
`default_nettype none

module mcfp_div_pipe (
    input  wire logic                       clk,
    input  wire logic                       advance,
    input  wire logic [mcfp_pkg::NUM_W-1:0] numerator,
    input  wire logic [mcfp_pkg::DEN_W-1:0] divisor,
    output logic      [mcfp_pkg::QUO_W-1:0] quotient
);
    import mcfp_pkg::*;

    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_stage
            localparam int Bit = QUO_W - 1 - k;

            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [QUO_W-1:0] quo_in;
            logic [NUM_W-1:0] shifted;
            logic [NUM_W-1:0] rem_next;
            logic [QUO_W-1:0] quo_next;

            // stage input select
            if (k == 0) begin : g_first
                assign rem_in = numerator;
                assign den_in = divisor;
                assign quo_in = '0;
            end
            else begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            // trial subtract of the shifted divisor
            always_comb
            begin
                shifted  = NUM_W'(den_in) << Bit;
                rem_next = rem_in;
                quo_next = quo_in;
                if (rem_in >= shifted)
                begin
                    rem_next      = rem_in - shifted;
                    quo_next[Bit] = 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                    quo_reg[k] <= quo_next;
                end
            end
        end
    endgenerate

    assign quotient = quo_reg[QUO_W-1];

endmodule

`default_nettype wire
